// ----- src/rrf_pkg.sv -----
// Shared types, constants and field widths of the rounded rectangle fill rasterizer.
package rrf_pkg;

	localparam int COORD_BITS_DEF = 13;
	localparam int CFG_BITS       = 13;
	localparam int CFG_IDX_BITS   = 2;
	localparam int ADDR_BITS      = 24;
	localparam int COLOR_BITS     = 16;
	localparam int POS_BITS       = 16;
	localparam int SIZE_BITS      = 15;
	localparam int QUEUE_DEPTH    = 4;

	localparam int unsigned RECIP6       = 43691;
	localparam int          RECIP6_SHIFT = 18;

	localparam logic [CFG_BITS-1:0] SURFACE_WIDTH_RST  = CFG_BITS'(320);
	localparam logic [CFG_BITS-1:0] SURFACE_HEIGHT_RST = CFG_BITS'(240);
	localparam logic [CFG_BITS-1:0] ROW_PITCH_RST      = CFG_BITS'(320);

	localparam logic [CFG_IDX_BITS-1:0] CFG_SURFACE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SURFACE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_PITCH      = 2'd2;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	typedef enum logic {
		JOB_BLANK,
		JOB_PIXEL
	} job_kind_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] surface_width;
		logic [CFG_BITS-1:0] surface_height;
		logic [CFG_BITS-1:0] row_pitch;
	} cfg_t;

	typedef struct packed {
		logic signed [POS_BITS-1:0] left;
		logic signed [POS_BITS-1:0] top;
		logic [SIZE_BITS-1:0]       width;
		logic [SIZE_BITS-1:0]       height;
		logic [SIZE_BITS-1:0]       radius;
		logic [COLOR_BITS-1:0]      color;
	} shape_t;

	typedef struct packed {
		job_kind_t kind;
		logic      done;
		logic      load;
		shape_t    shape;
	} job_t;

endpackage

// ----- src/rrf_req_if.sv -----
// Request channel: action and rectangle fields with valid/ready handshake.
interface rrf_req_if import rrf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic signed [POS_BITS-1:0] rect_x;
	logic signed [POS_BITS-1:0] rect_y;
	logic [SIZE_BITS-1:0]       rect_w;
	logic [SIZE_BITS-1:0]       rect_h;
	logic [COLOR_BITS-1:0]      fill_color;

	modport source (output valid, action, rect_x, rect_y, rect_w, rect_h, fill_color,
		input ready);
	modport sink (input valid, action, rect_x, rect_y, rect_w, rect_h, fill_color,
		output ready);
endinterface

// ----- src/rrf_res_if.sv -----
// Result channel: pixel write fields with valid/ready handshake.
interface rrf_res_if import rrf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  write_enable;
	logic [ADDR_BITS-1:0]  pixel_address;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  pass_done;

	modport source (output valid, write_enable, pixel_address, pixel_color, pass_done,
		input ready);
	modport sink (input valid, write_enable, pixel_address, pixel_color, pass_done,
		output ready);
endinterface

// ----- src/rounded_rect_fill_raster.sv -----
// Top level of the rounded rectangle fill rasterizer: configuration and channel wiring.
//
// Use: write surface_width, surface_height and row_pitch on the config port
// (cfg_write_en, cfg_index, cfg_data) while the block is idle. Send a start
// request (action 0) with the rectangle and colour, then one step request
// (action 1) per pixel of the clipped area. Every request yields exactly one
// result on res_ch: write enable, address row*pitch+column, colour, and
// pass_done on the last pixel, on a pass that ends at once, and when idle.
// Throughput is one request per cycle while the queue is not full, set by the
// front end scan counter and the single address multiplier in the back end.
// A result passes the queue, job, distance, square and output registers.
// A four-entry queue parts the front and back ends, so requests keep being
// accepted while a result waits; when res_ch stalls, the back end pipeline
// holds and req_ch.ready drops once the queue is full.
// Reset clears the pass state, the queue and the pipeline, and loads the
// register defaults 320, 240 and 320.
module rounded_rect_fill_raster import rrf_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write_en,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	rrf_req_if.sink                 req_ch,
	rrf_res_if.source               res_ch
);

	localparam int QW = $bits(job_t) + 2 * COORD_BITS;

	cfg_t cfg_q;

	logic                  push, pop, full, empty;
	job_t                  job_in, job_out;
	logic [COORD_BITS-1:0] col_in, row_in, col_out, row_out;
	logic [QW-1:0]         q_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.surface_width  <= SURFACE_WIDTH_RST;
			cfg_q.surface_height <= SURFACE_HEIGHT_RST;
			cfg_q.row_pitch      <= ROW_PITCH_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_SURFACE_WIDTH: begin
					cfg_q.surface_width <= cfg_data;
				end
				CFG_SURFACE_HEIGHT: begin
					cfg_q.surface_height <= cfg_data;
				end
				CFG_ROW_PITCH: begin
					cfg_q.row_pitch <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	rrf_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.req     (req_ch),
		.full    (full),
		.push    (push),
		.job     (job_in),
		.job_col (col_in),
		.job_row (row_in)
	);

	rrf_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data ({job_in, col_in, row_in}),
		.pop     (pop),
		.rd_data (q_rd),
		.full    (full),
		.empty   (empty)
	);

	assign {job_out, col_out, row_out} = q_rd;

	rrf_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.job     (job_out),
		.job_col (col_out),
		.job_row (row_out),
		.empty   (empty),
		.pop     (pop),
		.res     (res_ch)
	);

endmodule

// ----- src/rrf_front.sv -----
// Front end: accepts requests, clips the rectangle, tracks the scan and issues jobs.
module rrf_front import rrf_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	rrf_req_if.sink               req,
	input  logic                  full,
	output logic                  push,
	output job_t                  job,
	output logic [COORD_BITS-1:0] job_col,
	output logic [COORD_BITS-1:0] job_row
);

	localparam int SW = 19;
	localparam logic signed [SW-1:0] CMAX = SW'((1 << COORD_BITS) - 1);
	localparam logic signed [SW-1:0] ZERO = '0;

	logic                  busy_q;
	logic [COORD_BITS-1:0] col_q, row_q;
	logic [COORD_BITS-1:0] clip_left_q, clip_right_q, clip_bottom_q;

	logic signed [SW-1:0] x, y, w, h, swz, shz, sw, sh, pitch;
	logic signed [SW-1:0] right, bottom, left, top;
	logic                  bad;
	logic [30:0]           hprod;
	logic [SIZE_BITS-1:0]  hq, r0, radius;
	logic                  col_end, row_end;

	assign req.ready = !full;
	assign push      = req.valid && !full;

	always_comb begin
		x      = SW'(req.rect_x);
		y      = SW'(req.rect_y);
		w      = SW'({1'b0, req.rect_w});
		h      = SW'({1'b0, req.rect_h});
		swz    = SW'({1'b0, cfg.surface_width});
		shz    = SW'({1'b0, cfg.surface_height});
		pitch  = SW'({1'b0, cfg.row_pitch});
		sw     = (swz > CMAX) ? CMAX : swz;
		sh     = (shz > CMAX) ? CMAX : shz;
		right  = x + w;
		bottom = y + h;
		if (right > sw) begin
			right = sw;
		end
		if (bottom > sh) begin
			bottom = sh;
		end
		left = (x < ZERO) ? ZERO : x;
		top  = (y < ZERO) ? ZERO : y;
		bad  = (pitch < sw) || (sw == ZERO) || (sh == ZERO) || (w == ZERO) || (h == ZERO)
			|| (left >= right) || (top >= bottom);

		hprod  = 31'(req.rect_h) * 31'(RECIP6);
		hq     = SIZE_BITS'(hprod >> RECIP6_SHIFT);
		r0     = (hq == '0) ? SIZE_BITS'(1) : hq;
		radius = ({r0, 1'b0} > {1'b0, req.rect_w}) ? (req.rect_w >> 1) : r0;
	end

	assign col_end = ({1'b0, col_q} + 1'b1) >= {1'b0, clip_right_q};
	assign row_end = ({1'b0, row_q} + 1'b1) >= {1'b0, clip_bottom_q};

	always_comb begin
		job.kind         = JOB_BLANK;
		job.done         = 1'b1;
		job.load         = 1'b0;
		job.shape.left   = req.rect_x;
		job.shape.top    = req.rect_y;
		job.shape.width  = req.rect_w;
		job.shape.height = req.rect_h;
		job.shape.radius = radius;
		job.shape.color  = req.fill_color;
		job_col          = col_q;
		job_row          = row_q;
		if (req.action == ACT_START) begin
			job.done = bad;
			job.load = !bad;
		end else if (busy_q) begin
			job.kind = JOB_PIXEL;
			job.done = col_end && row_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			col_q         <= '0;
			row_q         <= '0;
			clip_left_q   <= '0;
			clip_right_q  <= '0;
			clip_bottom_q <= '0;
		end else if (push) begin
			if (req.action == ACT_START) begin
				busy_q <= !bad;
				if (!bad) begin
					clip_left_q   <= COORD_BITS'(left);
					clip_right_q  <= COORD_BITS'(right);
					clip_bottom_q <= COORD_BITS'(bottom);
					col_q         <= COORD_BITS'(left);
					row_q         <= COORD_BITS'(top);
				end
			end else if (busy_q) begin
				if (col_end) begin
					col_q <= clip_left_q;
					if (row_end) begin
						busy_q <= 1'b0;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- src/rrf_queue.sv -----
// Short first-in first-out job queue between the front and back ends.
module rrf_queue import rrf_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      count_q;

	assign full    = count_q == (PW+1)'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/rrf_back.sv -----
// Back end: address multiply, corner distance test and output register.
module rrf_back import rrf_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  job_t                  job,
	input  logic [COORD_BITS-1:0] job_col,
	input  logic [COORD_BITS-1:0] job_row,
	input  logic                  empty,
	output logic                  pop,
	rrf_res_if.source             res
);

	localparam int SW   = 19;
	localparam int PW   = COORD_BITS + CFG_BITS;
	localparam int SUMW = (PW + 1 > ADDR_BITS) ? PW + 1 : ADDR_BITS;
	localparam int DW   = SIZE_BITS;
	localparam int QW   = 2 * DW;
	localparam logic signed [SW-1:0] ONE  = SW'(1);
	localparam logic signed [SW-1:0] ZERO = '0;

	logic ce;

	shape_t shape_q;

	logic                  v_s1, done_s1;
	job_kind_t             kind_s1;
	logic [COORD_BITS-1:0] col_s1, row_s1;

	logic                  v_s2, done_s2, dxp_s2, dyp_s2;
	job_kind_t             kind_s2;
	logic [COORD_BITS-1:0] col_s2;
	logic [PW-1:0]         prod_s2;
	logic [DW-1:0]         dx_s2, dy_s2, r_s2;
	logic [COLOR_BITS-1:0] color_s2;

	logic                  v_s3, done_s3, corner_s3;
	job_kind_t             kind_s3;
	logic [ADDR_BITS-1:0]  addr_s3;
	logic [QW-1:0]         dx2_s3, dy2_s3, r2_s3;
	logic [COLOR_BITS-1:0] color_s3;

	logic                  out_valid_q, we_q, done_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [COLOR_BITS-1:0] color_q;

	logic signed [SW-1:0] px, py, sl, st, swd, shd, sr, lr, rr, tb, bb, dxw, dyw;
	logic                 outside;

	assign ce  = !out_valid_q || res.ready;
	assign pop = ce && !empty;

	always_comb begin
		px  = SW'({1'b0, col_s1});
		py  = SW'({1'b0, row_s1});
		sl  = SW'(shape_q.left);
		st  = SW'(shape_q.top);
		swd = SW'({1'b0, shape_q.width});
		shd = SW'({1'b0, shape_q.height});
		sr  = SW'({1'b0, shape_q.radius});
		lr  = sl + sr;
		rr  = sl + swd - sr - ONE;
		tb  = st + sr;
		bb  = st + shd - sr - ONE;
		if (px < lr) begin
			dxw = lr - px;
		end else if (px >= rr) begin
			dxw = px - rr;
		end else begin
			dxw = ZERO;
		end
		if (py < tb) begin
			dyw = tb - py;
		end else if (py >= bb) begin
			dyw = py - bb;
		end else begin
			dyw = ZERO;
		end
	end

	assign outside = corner_s3 && (({1'b0, dx2_s3} + {1'b0, dy2_s3}) > {1'b0, r2_s3});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (ce) begin
			v_s1        <= !empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && job.load) begin
			shape_q <= job.shape;
		end
		if (ce) begin
			kind_s1  <= job.kind;
			done_s1  <= job.done;
			col_s1   <= job_col;
			row_s1   <= job_row;

			kind_s2  <= kind_s1;
			done_s2  <= done_s1;
			col_s2   <= col_s1;
			prod_s2  <= PW'(row_s1) * PW'(cfg.row_pitch);
			dx_s2    <= DW'(dxw);
			dy_s2    <= DW'(dyw);
			dxp_s2   <= dxw > ZERO;
			dyp_s2   <= dyw > ZERO;
			r_s2     <= shape_q.radius;
			color_s2 <= shape_q.color;

			kind_s3   <= kind_s2;
			done_s3   <= done_s2;
			addr_s3   <= ADDR_BITS'(SUMW'(prod_s2) + SUMW'(col_s2));
			dx2_s3    <= QW'(dx_s2) * QW'(dx_s2);
			dy2_s3    <= QW'(dy_s2) * QW'(dy_s2);
			r2_s3     <= QW'(r_s2) * QW'(r_s2);
			corner_s3 <= dxp_s2 && dyp_s2;
			color_s3  <= color_s2;

			done_q <= done_s3;
			if (kind_s3 == JOB_PIXEL) begin
				we_q    <= !outside;
				addr_q  <= addr_s3;
				color_q <= color_s3;
			end else begin
				we_q    <= 1'b0;
				addr_q  <= '0;
				color_q <= '0;
			end
		end
	end

	assign res.valid         = out_valid_q;
	assign res.write_enable  = we_q;
	assign res.pixel_address = addr_q;
	assign res.pixel_color   = color_q;
	assign res.pass_done     = done_q;

endmodule

// ----- src/rrf_checker.sv -----
// Port-level checker for the rounded rectangle fill rasterizer, with its bind.
module rrf_checker import rrf_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  res_valid,
	input logic                  res_ready,
	input logic                  res_write_enable,
	input logic [ADDR_BITS-1:0]  res_pixel_address,
	input logic [COLOR_BITS-1:0] res_pixel_color,
	input logic                  res_pass_done
);

	localparam int CAP = QUEUE_DEPTH + 4;

	logic [4:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 5'(req_valid && req_ready) - 5'(res_valid && res_ready);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_write_enable)
			&& $stable(res_pixel_address) && $stable(res_pixel_color) && $stable(res_pass_done))
		else $error("result changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != '0)
		else $error("result without an outstanding request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 5'(CAP))
		else $error("more requests in flight than the pipeline holds");

endmodule

bind rounded_rect_fill_raster rrf_checker u_rrf_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req_ch.valid),
	.req_ready         (req_ch.ready),
	.res_valid         (res_ch.valid),
	.res_ready         (res_ch.ready),
	.res_write_enable  (res_ch.write_enable),
	.res_pixel_address (res_ch.pixel_address),
	.res_pixel_color   (res_ch.pixel_color),
	.res_pass_done     (res_ch.pass_done)
);
